// File: hdl/scapm_pkg.sv
`default_nettype none
package scapm_pkg;

    localparam int unsigned CFG_W     = 11;
    localparam int unsigned PAGE_W    = 10;
    localparam int unsigned DEV_W     = 12;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned WORD_SH   = 5;

    localparam int unsigned DEF_SWAP_CHUNKS     = 1024;
    localparam int unsigned DEF_TABLE_SLOTS     = 256;
    localparam int unsigned DEF_PAGES_PER_CHUNK = 4;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_QUERY   = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_DISABLED    = 2'd1,
        ST_NOT_SWAPPED = 2'd2,
        ST_EXHAUSTED   = 2'd3
    } t_status;

    typedef struct packed {
        t_op               operation;
        logic [PAGE_W-1:0] page_index;
    } t_in;

    typedef struct packed {
        t_status          status;
        logic             page_present;
        logic [DEV_W-1:0] device_page;
    } t_out;

    typedef struct packed {
        logic    accept;
        logic    div;
        logic    split;
        logic    look;
        logic    scan_run;
        logic    map_write;
        logic    clr_step;
        logic    res_load;
        t_status res_status;
        logic    res_present;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic disabled;
        logic in_table;
        logic mapped;
        logic present;
        logic found;
        logic scan_end;
        logic clr_last;
    } t_stat;

endpackage
`default_nettype wire

// File: hdl/scapm_ctrl.sv
`default_nettype none
module scapm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  scapm_pkg::t_op   i_in_op,
    input  logic             i_out_free,
    input  scapm_pkg::t_stat i_stat,
    output logic             o_in_ready,
    output scapm_pkg::t_cmd  o_cmd
);
    import scapm_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SPLIT,
        S_LOOK,
        S_SCAN,
        S_MAP,
        S_FIN
    } t_state;

    t_state  r_state;
    logic    r_release;
    t_status r_res_status;
    logic    r_res_present;
    logic    w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        o_cmd             = '0;
        o_cmd.accept      = w_accept;
        o_cmd.div         = (r_state == S_DIV);
        o_cmd.split       = (r_state == S_SPLIT);
        o_cmd.look        = (r_state == S_LOOK);
        o_cmd.scan_run    = (r_state == S_SCAN);
        o_cmd.map_write   = (r_state == S_MAP);
        o_cmd.clr_step    = (r_state == S_CLEAR);
        o_cmd.res_load    = (r_state == S_FIN) && i_out_free;
        o_cmd.res_status  = r_res_status;
        o_cmd.res_present = r_res_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_release     <= 1'b0;
            r_res_status  <= ST_OK;
            r_res_present <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_stat.clr_last) begin
                        r_state <= r_release ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_op == OP_RELEASE) begin
                            r_state       <= S_CLEAR;
                            r_release     <= 1'b1;
                            r_res_status  <= ST_OK;
                            r_res_present <= 1'b0;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_res_present <= 1'b0;
                    r_res_status  <= ST_OK;
                    r_state       <= S_FIN;
                    case (i_stat.op)
                        OP_WRITE: begin
                            if (i_stat.disabled) begin
                                r_res_status <= ST_DISABLED;
                            end else if (!i_stat.in_table) begin
                                r_res_status <= ST_EXHAUSTED;
                            end else if (i_stat.mapped) begin
                                r_state <= S_MAP;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        OP_QUERY: begin
                            r_res_present <= i_stat.present;
                        end
                        OP_READ: begin
                            if (i_stat.disabled) begin
                                r_res_status <= ST_DISABLED;
                            end else if (!i_stat.present) begin
                                r_res_status <= ST_NOT_SWAPPED;
                            end else begin
                                r_res_present <= 1'b1;
                            end
                        end
                        default: begin
                            r_res_status <= ST_OK;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (i_stat.found) begin
                        r_state <= S_MAP;
                    end else if (i_stat.scan_end) begin
                        r_res_status  <= ST_EXHAUSTED;
                        r_res_present <= 1'b0;
                        r_state       <= S_FIN;
                    end
                end
                S_MAP: begin
                    r_res_status  <= ST_OK;
                    r_res_present <= 1'b1;
                    r_state       <= S_FIN;
                end
                S_FIN: begin
                    if (i_out_free) begin
                        r_state   <= S_IDLE;
                        r_release <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/scapm_dp.sv
`default_nettype none
module scapm_dp #(
    parameter int unsigned SWAP_CHUNKS     = scapm_pkg::DEF_SWAP_CHUNKS,
    parameter int unsigned TABLE_SLOTS     = scapm_pkg::DEF_TABLE_SLOTS,
    parameter int unsigned PAGES_PER_CHUNK = scapm_pkg::DEF_PAGES_PER_CHUNK
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scapm_pkg::t_in              i_in_data,
    input  logic [scapm_pkg::CFG_W-1:0] i_cfg,
    input  scapm_pkg::t_cmd             i_cmd,
    output scapm_pkg::t_stat            o_stat,
    output scapm_pkg::t_out             o_result
);
    import scapm_pkg::*;

    localparam int unsigned WORDS   = (SWAP_CHUNKS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WAW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned EW      = $clog2(SWAP_CHUNKS + 1);
    localparam int unsigned CMPW    = (EW > CFG_W) ? EW : CFG_W;
    localparam int unsigned SAW     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned SBW     = (PAGES_PER_CHUNK > 1) ? $clog2(PAGES_PER_CHUNK) : 1;
    localparam int unsigned PPC     = PAGES_PER_CHUNK;
    localparam int unsigned ENW     = EW + PPC;
    localparam int unsigned CLR_N   = (WORDS > TABLE_SLOTS) ? WORDS : TABLE_SLOTS;
    localparam int unsigned CLW     = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int unsigned DIV_SH  = 20;
    localparam int unsigned DIV_MUL = ((1 << DIV_SH) + PPC - 1) / PPC;
    localparam int unsigned PW      = PAGE_W + DIV_SH + 1;

    logic [WORD_BITS-1:0] r_bm_mem [WORDS];
    logic [ENW-1:0]       r_map_mem [TABLE_SLOTS];

    t_op                  r_op;
    logic [PAGE_W-1:0]    r_page;
    logic [PAGE_W-1:0]    r_slot;
    logic [SBW-1:0]       r_sub;
    logic                 r_in_table;
    logic [EW-1:0]        r_chunk;
    logic [PPC-1:0]       r_pbits;
    logic [WORD_BITS-1:0] r_bm_rd;
    logic [ENW-1:0]       r_map_rd;
    logic [WAW-1:0]       r_scan_addr;
    logic [WAW-1:0]       r_chk_addr;
    logic                 r_chk_valid;
    logic [CLW-1:0]       r_clr;

    logic [EW-1:0]        w_eff;
    logic [EW-1:0]        w_eff_m1;
    logic [WAW-1:0]       w_last;
    logic [WORD_SH-1:0]   w_lim;
    logic [PW-1:0]        w_prod;
    logic [PAGE_W-1:0]    w_base;
    logic [SAW-1:0]       w_slot_addr;
    logic [EW-1:0]        w_map_chunkp1;
    logic [PPC-1:0]       w_map_pbits;
    logic [PPC-1:0]       w_bit;
    logic                 w_mapped;
    logic [WORD_BITS-1:0] w_cand;
    logic [WORD_SH-1:0]   w_pos;
    logic                 w_any;
    logic                 w_found;
    logic [EW-1:0]        w_new_chunk;
    logic                 w_clr_last;
    logic                 w_bm_we;
    logic [WAW-1:0]       w_bm_waddr;
    logic [WORD_BITS-1:0] w_bm_wdata;
    logic                 w_map_we;
    logic [SAW-1:0]       w_map_waddr;
    logic [ENW-1:0]       w_map_wdata;
    logic [31:0]          w_dev_full;

    // effective chunk count and last bitmap word
    assign w_eff    = (CMPW'(i_cfg) > CMPW'(SWAP_CHUNKS)) ? EW'(SWAP_CHUNKS) : EW'(i_cfg);
    assign w_eff_m1 = w_eff - EW'(1);
    assign w_last   = WAW'(w_eff_m1 >> WORD_SH);
    assign w_lim    = w_eff_m1[WORD_SH-1:0];

    // slot and page within slot
    assign w_prod      = PW'(r_page) * PW'(DIV_MUL);
    assign w_base      = PAGE_W'(32'(r_slot) * PPC);
    assign w_slot_addr = SAW'(r_slot);

    assign w_map_chunkp1 = r_map_rd[EW-1:0];
    assign w_map_pbits   = r_map_rd[ENW-1:EW];
    assign w_bit         = PPC'(1) << r_sub;
    assign w_mapped      = (w_map_chunkp1 != '0);

    // lowest free chunk in the checked word
    always_comb begin
        w_cand = '0;
        w_pos  = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            w_cand[b] = !r_bm_rd[b] && ((r_chk_addr != w_last) || (WORD_SH'(b) <= w_lim));
        end
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_cand[b]) begin
                w_pos = WORD_SH'(b);
            end
        end
    end

    assign w_any       = |w_cand;
    assign w_found     = r_chk_valid && w_any;
    assign w_new_chunk = EW'({r_chk_addr, w_pos});
    assign w_clr_last  = (r_clr == CLW'(CLR_N - 1));

    always_comb begin
        o_stat          = '0;
        o_stat.op       = r_op;
        o_stat.disabled = (i_cfg == '0);
        o_stat.in_table = r_in_table;
        o_stat.mapped   = w_mapped;
        o_stat.present  = r_in_table && w_mapped && |(w_map_pbits & w_bit);
        o_stat.found    = w_found;
        o_stat.scan_end = r_chk_valid && !w_any && (r_chk_addr == w_last);
        o_stat.clr_last = w_clr_last;
    end

    // memory write ports
    always_comb begin
        w_bm_we    = 1'b0;
        w_bm_waddr = r_chk_addr;
        w_bm_wdata = r_bm_rd | (WORD_BITS'(1) << w_pos);
        if (i_cmd.clr_step) begin
            w_bm_we    = (32'(r_clr) < WORDS);
            w_bm_waddr = WAW'(r_clr);
            w_bm_wdata = '0;
        end else if (i_cmd.scan_run && w_found) begin
            w_bm_we = 1'b1;
        end
    end

    always_comb begin
        w_map_we    = 1'b0;
        w_map_waddr = w_slot_addr;
        w_map_wdata = {r_pbits | w_bit, EW'(r_chunk + EW'(1))};
        if (i_cmd.clr_step) begin
            w_map_we    = (32'(r_clr) < TABLE_SLOTS);
            w_map_waddr = SAW'(r_clr);
            w_map_wdata = '0;
        end else if (i_cmd.map_write) begin
            w_map_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bm_we) begin
            r_bm_mem[w_bm_waddr] <= w_bm_wdata;
        end
        r_bm_rd <= r_bm_mem[r_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map_mem[w_map_waddr] <= w_map_wdata;
        end
        r_map_rd <= r_map_mem[w_slot_addr];
    end

    // scan and clear control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_chk_addr  <= '0;
            r_chk_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            if (i_cmd.look) begin
                r_scan_addr <= '0;
                r_chk_valid <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_scan_addr <= (r_scan_addr == w_last) ? r_scan_addr
                                                       : r_scan_addr + WAW'(1);
                r_chk_addr  <= r_scan_addr;
                r_chk_valid <= 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr <= w_clr_last ? '0 : r_clr + CLW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_in_data.operation;
            r_page <= i_in_data.page_index;
        end
        if (i_cmd.div) begin
            r_slot <= w_prod[DIV_SH +: PAGE_W];
        end
        if (i_cmd.split) begin
            r_sub      <= SBW'(r_page - w_base);
            r_in_table <= (32'(r_slot) < TABLE_SLOTS);
        end
        if (i_cmd.look) begin
            r_chunk <= w_map_chunkp1 - EW'(1);
            r_pbits <= w_map_pbits;
        end else if (i_cmd.scan_run && w_found) begin
            r_chunk <= w_new_chunk;
        end
    end

    assign w_dev_full = 32'(r_chunk) * 32'(PPC) + 32'(r_sub);

    always_comb begin
        o_result              = '0;
        o_result.status       = i_cmd.res_status;
        o_result.page_present = i_cmd.res_present;
        o_result.device_page  = i_cmd.res_present ? w_dev_full[DEV_W-1:0] : '0;
    end

endmodule
`default_nettype wire

// File: hdl/swap_chunk_allocator_and_page_map_unit.sv
`default_nettype none
// swap chunk allocator and page map
// input channel i_in_valid / o_in_ready carries one operation beat: write,
// read, query or release of a page of the object's swap space
// output channel o_out_valid / i_out_ready returns one result beat per input
// beat: status, page present flag and device page
// i_cfg_we / i_cfg_wdata write the swap chunk count, zero disables swap
// one operation at a time; read and query pass the states DIV, SPLIT, LOOK
// and FIN before the result register loads; a write to a mapped slot adds MAP
// write to an unmapped slot scans the free bitmap one 32-chunk word per cycle
// from its single read port, up to the word that holds the last usable chunk
// release clears the bitmap and the slot map one entry per cycle, stepping
// through as many entries as the larger of the two holds
// the next beat can be taken in the cycle after the result loads
// after reset the same clearing pass runs and o_in_ready stays low for it
// results sit in an output register; a new beat is accepted while one waits,
// and the block holds its finished result until the receiver takes the old one
module swap_chunk_allocator_and_page_map_unit #(
    parameter int unsigned SWAP_CHUNKS     = scapm_pkg::DEF_SWAP_CHUNKS,
    parameter int unsigned TABLE_SLOTS     = scapm_pkg::DEF_TABLE_SLOTS,
    parameter int unsigned PAGES_PER_CHUNK = scapm_pkg::DEF_PAGES_PER_CHUNK
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  scapm_pkg::t_in              i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output scapm_pkg::t_out             o_out_data,
    input  logic                        i_cfg_we,
    input  logic [scapm_pkg::CFG_W-1:0] i_cfg_wdata
);
    import scapm_pkg::*;

    logic [CFG_W-1:0] r_cfg;
    logic             r_out_valid;
    t_out             r_out_data;
    t_cmd             w_cmd;
    t_stat            w_stat;
    t_out             w_result;
    logic             w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (w_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.res_load) begin
            r_out_data <= w_result;
        end
    end

    scapm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.operation),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    scapm_dp #(
        .SWAP_CHUNKS     (SWAP_CHUNKS),
        .TABLE_SLOTS     (TABLE_SLOTS),
        .PAGES_PER_CHUNK (PAGES_PER_CHUNK)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cfg     (r_cfg),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_result  (w_result)
    );

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |-> w_out_free)
        else $error("result loaded over a waiting beat");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat accepted while busy");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("beat accepted before clearing pass");

    a_no_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !w_cmd.res_load)
        else $error("result produced in the accept cycle");
`endif

endmodule
`default_nettype wire

// File: dv/tb.sv
module tb;
    import scapm_pkg::*;

    localparam int unsigned SWAP_CHUNKS     = DEF_SWAP_CHUNKS;
    localparam int unsigned TABLE_SLOTS     = DEF_TABLE_SLOTS;
    localparam int unsigned PAGES_PER_CHUNK = DEF_PAGES_PER_CHUNK;
    localparam int unsigned DRAIN_CYCLES    = 300;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_data   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out             o_out_data;

    // model state
    logic [CFG_W-1:0] chunk_count;
    logic             chunk_used    [SWAP_CHUNKS];
    logic [CFG_W-1:0] slot_chunk_p1 [TABLE_SLOTS];
    logic [3:0]       slot_present  [TABLE_SLOTS];

    t_out             expected_results[$];
    int unsigned      mismatches = 0;
    bit               no_idle    = 1'b0;
    logic [PAGE_W-1:0] recent_page = '0;

    swap_chunk_allocator_and_page_map_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic t_out predict_page_map(t_in item);
        t_out        r;
        int unsigned slot;
        int unsigned sub;
        int unsigned eff;
        int unsigned c;
        logic        hit;
        slot = item.page_index / PAGES_PER_CHUNK;
        sub  = item.page_index % PAGES_PER_CHUNK;
        eff  = (chunk_count > SWAP_CHUNKS) ? SWAP_CHUNKS : chunk_count;
        r.status       = ST_OK;
        r.page_present = 1'b0;
        r.device_page  = '0;
        hit = slot < TABLE_SLOTS && slot_chunk_p1[slot] != 0 && slot_present[slot][sub];
        case (item.operation)
            OP_RELEASE: begin
                for (int s = 0; s < TABLE_SLOTS; s++) begin
                    if (slot_chunk_p1[s] != 0 && slot_chunk_p1[s] - 1 < SWAP_CHUNKS)
                        chunk_used[slot_chunk_p1[s] - 1] = 1'b0;
                    slot_chunk_p1[s] = '0;
                    slot_present[s]  = '0;
                end
            end
            OP_WRITE: begin
                if (eff == 0) begin
                    r.status = ST_DISABLED;
                end else if (slot >= TABLE_SLOTS) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    if (slot_chunk_p1[slot] == 0) begin
                        c = 0;
                        while (c < eff && chunk_used[c]) c++;
                        if (c < eff) begin
                            chunk_used[c]       = 1'b1;
                            slot_chunk_p1[slot] = CFG_W'(c + 1);
                        end
                    end
                    if (slot_chunk_p1[slot] == 0) begin
                        r.status = ST_EXHAUSTED;
                    end else begin
                        slot_present[slot][sub] = 1'b1;
                        r.page_present = 1'b1;
                    end
                end
            end
            OP_QUERY: begin
                r.page_present = hit;
            end
            default: begin
                if (eff == 0)
                    r.status = ST_DISABLED;
                else if (!hit)
                    r.status = ST_NOT_SWAPPED;
                else
                    r.page_present = 1'b1;
            end
        endcase
        if (r.page_present)
            r.device_page = DEV_W'((slot_chunk_p1[slot] - 1) * PAGES_PER_CHUNK + sub);
        return r;
    endfunction

    function automatic t_in page_beat(t_op op, int unsigned page);
        t_in b;
        b.operation  = op;
        b.page_index = PAGE_W'(page);
        return b;
    endfunction

    // valid stays high on return unless a random idle gap lowered it; caller sends again or lowers it
    task automatic send_beat(input t_in item);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!o_in_ready);
        expected_results.push_back(predict_page_map(item));
        if (item.operation == OP_WRITE)
            recent_page = item.page_index;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic set_chunk_count(input logic [CFG_W-1:0] value);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        chunk_count = value;
        cfg_we <= 1'b0;
    endtask

    // result beat checker and receiver stalls
    initial begin
        int unsigned stall;
        t_out        want;
        stall = 0;
        forever begin
            @(posedge clk);
            if (rst_n && o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result beat: expected none, actual %h",
                             $time, o_out_data);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== o_out_data.status) begin
                        $display("%0t status: expected %0d, actual %0d",
                                 $time, want.status, o_out_data.status);
                        mismatches++;
                    end
                    if (want.page_present !== o_out_data.page_present) begin
                        $display("%0t page_present: expected %0d, actual %0d",
                                 $time, want.page_present, o_out_data.page_present);
                        mismatches++;
                    end
                    if (want.device_page !== o_out_data.device_page) begin
                        $display("%0t device_page: expected %0d, actual %0d",
                                 $time, want.device_page, o_out_data.device_page);
                        mismatches++;
                    end
                end
            end
            if (no_idle) begin
                out_ready <= 1'b1;
            end else if (stall != 0) begin
                stall--;
                out_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic test_swap_disabled();
        send_beat(page_beat(OP_WRITE, 5));
        send_beat(page_beat(OP_READ, 5));
        send_beat(page_beat(OP_QUERY, 5));
        send_beat(page_beat(OP_RELEASE, 0));
    endtask

    task automatic test_map_and_exhaust();
        set_chunk_count(2);
        send_beat(page_beat(OP_WRITE, 0));
        send_beat(page_beat(OP_WRITE, 3));
        send_beat(page_beat(OP_WRITE, 1023));
        send_beat(page_beat(OP_READ, 3));
        send_beat(page_beat(OP_READ, 1));
        send_beat(page_beat(OP_QUERY, 1023));
        send_beat(page_beat(OP_WRITE, 4));
        send_beat(page_beat(OP_QUERY, 4));
    endtask

    task automatic test_lowered_count();
        set_chunk_count(1);
        send_beat(page_beat(OP_WRITE, 1022));
        send_beat(page_beat(OP_READ, 1022));
        set_chunk_count(0);
        send_beat(page_beat(OP_QUERY, 0));
        send_beat(page_beat(OP_READ, 0));
        send_beat(page_beat(OP_WRITE, 2));
        send_beat(page_beat(OP_RELEASE, 1023));
        send_beat(page_beat(OP_QUERY, 0));
    endtask

    task automatic test_full_count();
        set_chunk_count('1);
        send_beat(page_beat(OP_WRITE, 1020));
        send_beat(page_beat(OP_READ, 1020));
        send_beat(page_beat(OP_RELEASE, 512));
    endtask

    task automatic test_random(input logic [CFG_W-1:0] count, input int unsigned beats);
        int unsigned pick;
        int unsigned page;
        t_op         op;
        set_chunk_count(count);
        for (int i = 0; i < beats; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 42)      op = OP_WRITE;
            else if (pick < 68) op = OP_READ;
            else if (pick < 96) op = OP_QUERY;
            else                op = OP_RELEASE;
            pick = $urandom_range(0, 2);
            if (pick == 0)      page = recent_page ^ $urandom_range(0, 3);
            else if (pick == 1) page = $urandom_range(0, 63);
            else                page = $urandom_range(0, 1023);
            send_beat(page_beat(op, page));
        end
    endtask

    initial begin
        chunk_count = '0;
        for (int c = 0; c < SWAP_CHUNKS; c++) chunk_used[c] = 1'b0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            slot_chunk_p1[s] = '0;
            slot_present[s]  = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        set_chunk_count(0);

        test_swap_disabled();
        test_map_and_exhaust();
        test_lowered_count();
        test_full_count();

        test_random(1024, 100);
        test_random(5, 100);
        test_random('1, 100);
        test_random(32, 100);
        test_random(0, 60);
        test_random(CFG_W'($urandom_range(0, 2047)), 100);
        test_random(1, 80);
        test_random(100, 80);
        no_idle = 1'b1;
        test_random(CFG_W'($urandom_range(2, 40)), 80);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
